// ===== src/odith_pkg.sv =====
// Shared types and constants for the ordered-dither RGB888 to RGB565 converter.
// Used by the front, queue, back and top-level modules; no dependencies.
package odith_pkg;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 13'd256;
	localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 13'd240;

	localparam int QUEUE_DEPTH = 2;

	// 4x4 Bayer thresholds, indexed by {row[1:0], col[1:0]}
	localparam logic [3:0] BAYER_TAB [0:15] = '{
		4'd0,  4'd8,  4'd2,  4'd10,
		4'd12, 4'd4,  4'd14, 4'd6,
		4'd3,  4'd11, 4'd1,  4'd9,
		4'd15, 4'd7,  4'd13, 4'd5
	};

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [3:0] thresh;
		logic       last;
	} item_t;

endpackage

// ===== src/odith_front.sv =====
// Front end: configuration registers, raster counters, Bayer threshold lookup.
// Tags each accepted pixel and pushes it into the queue. Uses odith_pkg.
module odith_front #(
	parameter int MAX_WIDTH  = odith_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = odith_pkg::MAX_HEIGHT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [odith_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [odith_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               pix_valid,
	input  logic                               queue_full,
	input  logic [7:0]                         red_in,
	input  logic [7:0]                         green_in,
	input  logic [7:0]                         blue_in,
	output logic                               push,
	output odith_pkg::item_t                   push_item
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int SWC = ((odith_pkg::CFG_DATA_W > CW) ? odith_pkg::CFG_DATA_W : CW) + 1;
	localparam int SWR = ((odith_pkg::CFG_DATA_W > RW) ? odith_pkg::CFG_DATA_W : RW) + 1;

	logic [odith_pkg::CFG_DATA_W-1:0] frame_width_q;
	logic [odith_pkg::CFG_DATA_W-1:0] frame_height_q;
	logic [CW-1:0]                    col_q;
	logic [RW-1:0]                    row_q;

	logic [SWC-1:0] w_ext;
	logic [SWC-1:0] col_lastidx;
	logic [SWR-1:0] h_ext;
	logic [SWR-1:0] row_lastidx;
	logic           last_col;
	logic           last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= odith_pkg::FRAME_WIDTH_RST;
			frame_height_q <= odith_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				odith_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				odith_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// last valid index after clamping the size into 1..MAX
	always_comb begin
		w_ext = SWC'(frame_width_q);
		if (w_ext == '0) begin
			col_lastidx = '0;
		end else if (w_ext > SWC'(MAX_WIDTH)) begin
			col_lastidx = SWC'(MAX_WIDTH) - SWC'(1);
		end else begin
			col_lastidx = w_ext - SWC'(1);
		end
		h_ext = SWR'(frame_height_q);
		if (h_ext == '0) begin
			row_lastidx = '0;
		end else if (h_ext > SWR'(MAX_HEIGHT)) begin
			row_lastidx = SWR'(MAX_HEIGHT) - SWR'(1);
		end else begin
			row_lastidx = h_ext - SWR'(1);
		end
	end

	assign last_col = (SWC'(col_q) >= col_lastidx);
	assign last_row = (SWR'(row_q) >= row_lastidx);

	assign push = pix_valid && !queue_full;

	always_comb begin
		push_item.red    = red_in;
		push_item.green  = green_in;
		push_item.blue   = blue_in;
		push_item.thresh = odith_pkg::BAYER_TAB[{row_q[1:0], col_q[1:0]}];
		push_item.last   = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

`ifndef SYNTH
	a_wrap_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_item.last) |=> (col_q == '0 && row_q == '0))
		else $error("counters did not wrap after last pixel of frame");
`endif

endmodule

// ===== src/odith_fifo.sv =====
// Short queue between front and back so each side stalls on its own.
// Holds tagged pixels of type odith_pkg::item_t.
module odith_fifo #(
	parameter int DEPTH = odith_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  odith_pkg::item_t push_item,
	output logic             full,
	input  logic             pop,
	output logic             pop_valid,
	output odith_pkg::item_t pop_item
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	odith_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	assign full      = (count_q == NW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + NW'(1);
				2'b01:   count_q <= count_q - NW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTH
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(DEPTH))
		else $error("queue count above depth");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push && count_q == NW'(1)) |=> !pop_valid)
		else $error("queue not empty after popping its only entry");
`endif

endmodule

// ===== src/odith_back.sv =====
// Back end: two-stage quantizer. Stage 1 forms the scaled channel sums,
// stage 2 divides by 255, saturates green and packs RGB565. Uses odith_pkg.
module odith_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  odith_pkg::item_t q_item,
	output logic             pop,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [15:0]      pixel_565,
	output logic             frame_last
);

	logic        valid_s1;
	logic [12:0] sum_r_s1;
	logic [14:0] sum_g_s1;
	logic [12:0] sum_b_s1;
	logic        last_s1;

	logic        valid_s2;
	logic [15:0] pixel_s2;
	logic        last_s2;

	logic        adv;
	logic [7:0]  qr;
	logic [7:0]  qg;
	logic [7:0]  qb;
	logic [5:0]  g6;

	// floor(x / 255) for x below 32768
	function automatic logic [7:0] div255(input logic [14:0] x);
		logic [15:0] y;
		y = 16'(x) + 16'(x[14:8]) + 16'd1;
		return y[15:8];
	endfunction

	assign adv = !valid_s2 || !res_stall;
	assign pop = q_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_r_s1 <= 13'(q_item.red) * 13'd31 + 13'({q_item.thresh, 4'b0}) + 13'd8;
			sum_g_s1 <= 15'(q_item.green) * 15'd63 + 15'({q_item.thresh, 5'b0}) + 15'd16;
			sum_b_s1 <= 13'(q_item.blue) * 13'd31 + 13'({q_item.thresh, 4'b0}) + 13'd8;
			last_s1  <= q_item.last;
		end
	end

	assign qr = div255(15'(sum_r_s1));
	assign qg = div255(sum_g_s1);
	assign qb = div255(15'(sum_b_s1));
	// green can reach 64 at the top of the range: clip
	assign g6 = (qg > 8'd63) ? 6'd63 : qg[5:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_s2 <= {qr[4:0], g6, qb[4:0]};
			last_s2  <= last_s1;
		end
	end

	assign res_valid  = valid_s2;
	assign pixel_565  = pixel_s2;
	assign frame_last = last_s2;

`ifndef SYNTH
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |-> (!pop ##1 $stable(valid_s1)))
		else $error("stage 1 moved while output stalled");
`endif

endmodule

// ===== src/ordered_dither_rgb888_to_rgb565.sv =====
// Ordered-dither (4x4 Bayer) RGB888 to RGB565 converter, raster-order stream.
// Throughput: one pixel per cycle while res_stall is low; the 2-entry queue and the two
// quantizer stages each move one item a cycle unless the output stalls. Path: queue write
// at the input transfer, then sum stage, then divide/pack stage drives res_valid.
// Reset: counters to 0, frame_width 256, frame_height 240, queue and pipe empty.
module ordered_dither_rgb888_to_rgb565 #(
	parameter int MAX_WIDTH  = odith_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = odith_pkg::MAX_HEIGHT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [odith_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [odith_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               pix_valid,
	output logic                               pix_stall,
	input  logic [7:0]                         red_in,
	input  logic [7:0]                         green_in,
	input  logic [7:0]                         blue_in,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic [15:0]                        pixel_565,
	output logic                               frame_last
);

	logic             push;
	odith_pkg::item_t push_item;
	logic             full;
	logic             pop;
	logic             q_valid;
	odith_pkg::item_t q_item;

	assign pix_stall = full;

	odith_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pix_valid  (pix_valid),
		.queue_full (full),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.push       (push),
		.push_item  (push_item)
	);

	odith_fifo #(
		.DEPTH (odith_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_valid (q_valid),
		.pop_item  (q_item)
	);

	odith_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.pixel_565  (pixel_565),
		.frame_last (frame_last)
	);

endmodule

// ===== test/tb_ordered_dither_rgb888_to_rgb565.sv =====
// Testbench for ordered_dither_rgb888_to_rgb565: drives raster pixels and frame sizes,
// predicts each RGB565 result and end-of-frame flag, and checks them in order.
// Depends on odith_pkg and the converter top level only.
module tb_ordered_dither_rgb888_to_rgb565;

	localparam int MAX_W       = odith_pkg::MAX_WIDTH_DEF;
	localparam int MAX_H       = odith_pkg::MAX_HEIGHT_DEF;
	localparam int NUM_PHASES  = 12;
	localparam int PHASE_ITEMS = 86;
	localparam int HOLD_PHASE  = 5;
	localparam int HOLD_CYCLES = 60;
	localparam int CYCLE_LIMIT = 200000;

	// Bayer thresholds, row-major, indexed by row*4 + column
	localparam int DITHER_THRESH [16] = '{
		0, 8, 2, 10,
		12, 4, 14, 6,
		3, 11, 1, 9,
		15, 7, 13, 5
	};

	typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_e;

	typedef struct packed {
		logic [15:0] px;
		logic        last;
	} px_exp_t;

	typedef struct packed {
		row_kind_e                         kind;
		logic [odith_pkg::CFG_INDEX_W-1:0] idx;
		logic [odith_pkg::CFG_DATA_W-1:0]  val;
		logic [7:0]                        r;
		logic [7:0]                        g;
		logic [7:0]                        b;
		logic                              typed;
		px_exp_t                           want;
	} stim_row_t;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic [odith_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [odith_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                              pix_valid;
	logic                              pix_stall;
	logic [7:0]                        red_in;
	logic [7:0]                        green_in;
	logic [7:0]                        blue_in;
	logic                              res_valid;
	logic                              res_stall;
	logic [15:0]                       pixel_565;
	logic                              frame_last;

	// predictor copy of the size registers and raster position
	logic [odith_pkg::CFG_DATA_W-1:0] size_w;
	logic [odith_pkg::CFG_DATA_W-1:0] size_h;
	int                               rast_col;
	int                               rast_row;

	px_exp_t   pending_px [$];
	stim_row_t dir_tab [$];
	int        err_count;
	int        got_count;
	int        cycles;
	logic      no_idle;
	logic      hold_req;

	ordered_dither_rgb888_to_rgb565 dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.pixel_565  (pixel_565),
		.frame_last (frame_last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int extent_of(logic [odith_pkg::CFG_DATA_W-1:0] v, int maxv);
		if (v == 0) return 1;
		if (int'(v) > maxv) return maxv;
		return int'(v);
	endfunction

	// quantize one pixel at the current raster position, then advance it
	function automatic px_exp_t predict_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int w, h, th, rq, gq, bq;
		logic end_col, end_row;
		px_exp_t e;
		w = extent_of(size_w, MAX_W);
		h = extent_of(size_h, MAX_H);
		th = DITHER_THRESH[(rast_row % 4) * 4 + (rast_col % 4)];
		rq = (int'(r) * 31 + th * 16 + 8) / 255;
		gq = (int'(g) * 63 + th * 32 + 16) / 255;
		bq = (int'(b) * 31 + th * 16 + 8) / 255;
		if (rq > 31) rq = 31;
		if (gq > 63) gq = 63;
		if (bq > 31) bq = 31;
		end_col = (rast_col + 1 >= w);
		end_row = (rast_row + 1 >= h);
		e.px = {rq[4:0], gq[5:0], bq[4:0]};
		e.last = end_col && end_row;
		if (end_col) begin
			rast_col = 0;
			rast_row = end_row ? 0 : rast_row + 1;
		end else begin
			rast_col = rast_col + 1;
		end
		return e;
	endfunction

	function automatic stim_row_t pix_row(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		return '{ROW_PIXEL, '0, '0, r, g, b, 1'b0, '0};
	endfunction

	function automatic stim_row_t pix_want(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [15:0] px, logic last);
		return '{ROW_PIXEL, '0, '0, r, g, b, 1'b1, {px, last}};
	endfunction

	function automatic stim_row_t write_row(logic [odith_pkg::CFG_INDEX_W-1:0] idx,
			logic [odith_pkg::CFG_DATA_W-1:0] val);
		return '{ROW_WRITE, idx, val, '0, '0, '0, 1'b0, '0};
	endfunction

	// favor the channel extremes
	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		err_count++;
		$display("result %0d: %s got 'h%0h want 'h%0h", got_count, what, got, want);
	endtask

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic typed, input px_exp_t want);
		int gap;
		px_exp_t pred;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		red_in    <= r;
		green_in  <= g;
		blue_in   <= b;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
		pred = predict_pixel(r, g, b);
		pending_px.push_back(typed ? want : pred);
	endtask

	// drop valid and let every outstanding transfer come back
	task automatic wait_idle();
		pix_valid <= 1'b0;
		while (pending_px.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [odith_pkg::CFG_INDEX_W-1:0] idx,
			input logic [odith_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == odith_pkg::REG_FRAME_WIDTH)
			size_w = val;
		else if (idx == odith_pkg::REG_FRAME_HEIGHT)
			size_h = val;
	endtask

	initial begin : cycle_guard
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : result_sink
		int gap;
		px_exp_t want;
		logic hold_done;
		hold_done = 1'b0;
		res_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = ((got_count / 50) % 3 == 1) ? 0 : $urandom_range(0, 4);
			if (hold_req && !hold_done) begin
				gap = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (gap > 0) begin
				res_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
			got_count++;
			if (pending_px.size() == 0) begin
				report_mismatch("unexpected transfer", pixel_565, 0);
			end else begin
				want = pending_px.pop_front();
				if (pixel_565 !== want.px)
					report_mismatch("pixel_565", pixel_565, want.px);
				if (frame_last !== want.last)
					report_mismatch("frame_last", frame_last, want.last);
			end
		end
	end

	initial begin : pixel_source
		int ph, k;
		logic [odith_pkg::CFG_DATA_W-1:0] w, h;
		stim_row_t row;
		no_idle   = 1'b0;
		hold_req  = 1'b0;
		size_w    = odith_pkg::FRAME_WIDTH_RST;
		size_h    = odith_pkg::FRAME_HEIGHT_RST;
		rast_col  = 0;
		rast_row  = 0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		pix_valid <= 1'b0;
		red_in    <= '0;
		green_in  <= '0;
		blue_in   <= '0;

		// reset sizes, then a shrink to 1x1 mid-row, then one full 4x4 matrix walk
		dir_tab.push_back(pix_want(8'd0, 8'd0, 8'd0, 16'h0000, 1'b0));
		dir_tab.push_back(pix_want(8'd255, 8'd255, 8'd255, 16'hFFFF, 1'b0));
		dir_tab.push_back(write_row(odith_pkg::REG_FRAME_WIDTH, 13'd1));
		dir_tab.push_back(write_row(odith_pkg::REG_FRAME_HEIGHT, 13'd1));
		dir_tab.push_back(pix_want(8'd0, 8'd0, 8'd0, 16'h0000, 1'b1));
		dir_tab.push_back(pix_want(8'd255, 8'd0, 8'd255, 16'hF81F, 1'b1));
		dir_tab.push_back(write_row(odith_pkg::REG_FRAME_WIDTH, 13'd4));
		dir_tab.push_back(write_row(odith_pkg::REG_FRAME_HEIGHT, 13'd4));
		dir_tab.push_back(pix_row(8'h55, 8'hAA, 8'h0F));
		dir_tab.push_back(pix_row(8'd128, 8'd127, 8'd129));
		dir_tab.push_back(pix_row(8'd1, 8'd254, 8'd2));
		dir_tab.push_back(pix_row(8'hF0, 8'h33, 8'hCC));
		dir_tab.push_back(pix_row(8'd255, 8'd0, 8'd0));
		dir_tab.push_back(pix_row(8'd0, 8'd255, 8'd0));
		dir_tab.push_back(pix_row(8'd0, 8'd0, 8'd255));
		dir_tab.push_back(pix_row(8'd100, 8'd200, 8'd50));
		dir_tab.push_back(pix_row(8'h80, 8'h01, 8'hFE));
		dir_tab.push_back(pix_row(8'd17, 8'd34, 8'd51));
		dir_tab.push_back(pix_row(8'd254, 8'd253, 8'd252));
		dir_tab.push_back(pix_row(8'd7, 8'd8, 8'd9));
		// largest threshold: green would reach 64 and must saturate
		dir_tab.push_back(pix_want(8'd0, 8'd255, 8'd0, 16'h07E0, 1'b0));
		dir_tab.push_back(pix_row(8'd255, 8'd255, 8'd0));
		dir_tab.push_back(pix_row(8'd255, 8'd255, 8'd255));
		dir_tab.push_back(pix_want(8'd0, 8'd0, 8'd0, 16'h0000, 1'b1));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			row = dir_tab[i];
			if (row.kind == ROW_WRITE) begin
				wait_idle();
				write_reg(row.idx, row.val);
			end else begin
				send_pixel(row.r, row.g, row.b, row.typed, row.want);
			end
		end

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin w = 13'd0;    h = 13'd0;    end
				1: begin w = 13'h1FFF; h = 13'd3;    end
				2: begin w = 13'd4096; h = 13'd4096; end
				3: begin w = 13'd3;    h = 13'd2;    end
				4: begin w = 13'd8;    h = 13'd4;    end
				5: begin w = 13'd8;    h = 13'd1;    end
				default: begin
					w = 13'($urandom_range(1, 12));
					h = 13'($urandom_range(1, 6));
				end
			endcase
			wait_idle();
			write_reg(odith_pkg::REG_FRAME_WIDTH, w);
			write_reg(odith_pkg::REG_FRAME_HEIGHT, h);
			no_idle = (ph % 3 == 2);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				// stall the sink for a long stretch while transfers keep coming
				if (ph == HOLD_PHASE && k == 10)
					hold_req = 1'b1;
				send_pixel(pick_level(), pick_level(), pick_level(), 1'b0, '0);
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
